@@ hdl/yuvrgb_pkg.sv @@
// Package for the YUYV to RGB converter: coefficients, stage payload types,
// and the clamp and pack functions. No dependencies.
`default_nettype none

package yuvrgb_pkg;

  localparam int unsigned ProdW = 20;
  localparam int unsigned SumW  = 21;

  localparam logic signed [ProdW-1:0] CoefY  = 20'sd1192;
  localparam logic signed [ProdW-1:0] CoefRv = 20'sd1634;
  localparam logic signed [ProdW-1:0] CoefGv = 20'sd833;
  localparam logic signed [ProdW-1:0] CoefGu = 20'sd400;
  localparam logic signed [ProdW-1:0] CoefBu = 20'sd2066;
  localparam logic signed [ProdW-1:0] LumaOfs   = 20'sd16;
  localparam logic signed [ProdW-1:0] ChromaOfs = 20'sd128;
  localparam logic [7:0] ChanMax = 8'hFF;

  localparam logic FmtRgb888 = 1'b0;
  localparam logic FmtRgb565 = 1'b1;

  typedef struct packed {
    logic signed [ProdW-1:0] yt0;
    logic signed [ProdW-1:0] yt1;
    logic signed [ProdW-1:0] rv;
    logic signed [ProdW-1:0] gv;
    logic signed [ProdW-1:0] gu;
    logic signed [ProdW-1:0] bu;
    logic                    frame_end;
  } prod_t;

  typedef struct packed {
    logic signed [SumW-1:0] r0;
    logic signed [SumW-1:0] g0;
    logic signed [SumW-1:0] b0;
    logic signed [SumW-1:0] r1;
    logic signed [SumW-1:0] g1;
    logic signed [SumW-1:0] b1;
    logic                   frame_end;
  } sum_t;

  function automatic logic [7:0] clamp_chan(input logic signed [SumW-1:0] sum);
    logic [SumW-11:0] shifted;
    logic [7:0]       res;
    shifted = sum[SumW-1:10];
    if (sum[SumW-1]) begin
      res = 8'd0;
    end else if (shifted > {{(SumW-18){1'b0}}, ChanMax}) begin
      res = ChanMax;
    end else begin
      res = shifted[7:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic fmt);
    logic [23:0] res;
    if (fmt == FmtRgb565) begin
      res = {8'd0, r[7:3], g[7:2], b[7:3]};
    end else begin
      res = {b, g, r};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/yuyv_to_rgb_pixel_converter.sv @@
// Top level of the YUYV 4:2:2 to RGB converter: format register on the APB port
// and the three pipeline stages. Depends on yuvrgb_pkg, yuvrgb_prod, yuvrgb_sum, yuvrgb_pack.
//
// One YUYV macropixel is taken on every clock in which start is high (busy is
// always low), and its two RGB pixels appear after the product, sum and
// clamp/pack register stages, with valid_o high for exactly one cycle. The
// receiver cannot stall, so results must be taken as they come. Write
// out_format at byte address 0 only while no pixel is in the pipeline.
`default_nettype none

module yuyv_to_rgb_pixel_converter import yuvrgb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  luma_first_i,
  input  wire logic [7:0]  chroma_blue_i,
  input  wire logic [7:0]  luma_second_i,
  input  wire logic [7:0]  chroma_red_i,
  input  wire logic        frame_end_in_i,
  output logic             valid_o,
  output logic [23:0]      pixel_first_o,
  output logic [23:0]      pixel_second_o,
  output logic             frame_end_out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic  fmt_q, fmt_d, cfg_wr;
  logic  prod_valid, sum_valid;
  prod_t prod;
  sum_t  sum;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign fmt_d  = cfg_wr ? pwdata[0] : fmt_q;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtRgb888;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  yuvrgb_prod u_prod (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start & ~busy),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .frame_end_i   (frame_end_in_i),
    .valid_o       (prod_valid),
    .prod_o        (prod)
  );

  yuvrgb_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  yuvrgb_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (sum_valid),
    .sum_i          (sum),
    .fmt_i          (fmt_q),
    .valid_o        (valid_o),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .frame_end_o    (frame_end_out_o)
  );

endmodule

`default_nettype wire

@@ hdl/yuvrgb_prod.sv @@
// Stage one: remove the luma and chroma offsets and form all coefficient products.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_prod import yuvrgb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] luma_first_i,
  input  wire logic [7:0] chroma_blue_i,
  input  wire logic [7:0] luma_second_i,
  input  wire logic [7:0] chroma_red_i,
  input  wire logic       frame_end_i,
  output logic            valid_o,
  output prod_t           prod_o
);

  logic signed [ProdW-1:0] y0_off, y1_off, cu_off, cv_off;
  prod_t prod_d, prod_q;
  logic  valid_q;

  always_comb begin
    y0_off = $signed({12'd0, luma_first_i})  - LumaOfs;
    y1_off = $signed({12'd0, luma_second_i}) - LumaOfs;
    cu_off = $signed({12'd0, chroma_blue_i}) - ChromaOfs;
    cv_off = $signed({12'd0, chroma_red_i})  - ChromaOfs;
    prod_d.yt0       = y0_off * CoefY;
    prod_d.yt1       = y1_off * CoefY;
    prod_d.rv        = cv_off * CoefRv;
    prod_d.gv        = cv_off * CoefGv;
    prod_d.gu        = cu_off * CoefGu;
    prod_d.bu        = cu_off * CoefBu;
    prod_d.frame_end = frame_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

@@ hdl/yuvrgb_sum.sv @@
// Stage two: combine the products into the R, G and B sums of both pixels.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_sum import yuvrgb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire prod_t prod_i,
  output logic       valid_o,
  output sum_t       sum_o
);

  logic signed [SumW-1:0] yt0, yt1, rv, gv, gu, bu;
  sum_t sum_d, sum_q;
  logic valid_q;

  always_comb begin
    yt0 = SumW'(prod_i.yt0);
    yt1 = SumW'(prod_i.yt1);
    rv  = SumW'(prod_i.rv);
    gv  = SumW'(prod_i.gv);
    gu  = SumW'(prod_i.gu);
    bu  = SumW'(prod_i.bu);
    sum_d.r0        = yt0 + rv;
    sum_d.g0        = yt0 - gv - gu;
    sum_d.b0        = yt0 + bu;
    sum_d.r1        = yt1 + rv;
    sum_d.g1        = yt1 - gv - gu;
    sum_d.b1        = yt1 + bu;
    sum_d.frame_end = prod_i.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

@@ hdl/yuvrgb_pack.sv @@
// Stage three: clamp each channel to 0..255 and pack both pixels in the selected format.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_pack import yuvrgb_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire sum_t   sum_i,
  input  wire logic   fmt_i,
  output logic        valid_o,
  output logic [23:0] pixel_first_o,
  output logic [23:0] pixel_second_o,
  output logic        frame_end_o
);

  logic [23:0] pix0_d, pix0_q, pix1_d, pix1_q;
  logic        fe_q, valid_q;

  always_comb begin
    pix0_d = pack_pixel(clamp_chan(sum_i.r0), clamp_chan(sum_i.g0),
                        clamp_chan(sum_i.b0), fmt_i);
    pix1_d = pack_pixel(clamp_chan(sum_i.r1), clamp_chan(sum_i.g1),
                        clamp_chan(sum_i.b1), fmt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix0_q <= pix0_d;
    pix1_q <= pix1_d;
    fe_q   <= sum_i.frame_end;
  end

  assign valid_o        = valid_q;
  assign pixel_first_o  = pix0_q;
  assign pixel_second_o = pix1_q;
  assign frame_end_o    = fe_q;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the YUYV 4:2:2 to RGB pixel-pair converter.
// Predicts each pixel pair in the output format in effect (both formats are exercised) and checks every result strobe.
// Depends on yuvrgb_pkg and yuyv_to_rgb_pixel_converter.

module testbench;
  import yuvrgb_pkg::*;

  localparam int KLuma   = 1192;
  localparam int KRedV   = 1634;
  localparam int KGreenV = 833;
  localparam int KGreenU = 400;
  localparam int KBlueU  = 2066;
  localparam int ChanTop = 255;

  localparam logic [2:0] AddrOutFormat = 3'd0;
  localparam logic [2:0] AddrUnmapped  = 3'd4;

  localparam int StallLimit = 1000;
  localparam int PipeDepth  = 3;

  typedef struct packed {
    logic [23:0] px_first;
    logic [23:0] px_second;
    logic        frame_end;
  } rgb_pair_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [7:0]  luma_first_i   = 8'd0;
  logic [7:0]  chroma_blue_i  = 8'd0;
  logic [7:0]  luma_second_i  = 8'd0;
  logic [7:0]  chroma_red_i   = 8'd0;
  logic        frame_end_in_i = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = 3'd0;
  logic [31:0] pwdata         = 32'd0;
  logic        busy;
  logic        valid_o;
  logic [23:0] pixel_first_o;
  logic [23:0] pixel_second_o;
  logic        frame_end_out_o;
  logic [31:0] prdata;
  logic        pready;

  logic      fmt_shadow = FmtRgb888;
  rgb_pair_t pending_pairs[$];
  int        mismatch_count = 0;
  int        stall_cycles   = 0;
  int        calm_left      = 0;

  yuyv_to_rgb_pixel_converter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .frame_end_in_i (frame_end_in_i),
    .valid_o        (valid_o),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .frame_end_out_o(frame_end_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] sat_channel(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc >>> 10;
    return (q > ChanTop) ? 8'(ChanTop) : 8'(q);
  endfunction

  function automatic logic [23:0] encode_pixel(input logic [7:0] luma, input int cb,
                                               input int cr, input logic fmt);
    int          yt;
    logic [7:0]  r, g, b;
    logic [23:0] word;
    yt = KLuma * (int'(luma) - 16);
    r  = sat_channel(yt + KRedV * cr);
    g  = sat_channel(yt - KGreenV * cr - KGreenU * cb);
    b  = sat_channel(yt + KBlueU * cb);
    if (fmt == FmtRgb565) begin
      word = ((24'(r) >> 3) << 11) | ((24'(g) >> 2) << 5) | (24'(b) >> 3);
    end else begin
      word = {b, g, r};
    end
    return word;
  endfunction

  function automatic rgb_pair_t convert_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                                   input logic [7:0] y1, input logic [7:0] v,
                                                   input logic fe, input logic fmt);
    rgb_pair_t pair;
    int        cb, cr;
    cb = int'(u) - 128;
    cr = int'(v) - 128;
    pair.px_first  = encode_pixel(y0, cb, cr, fmt);
    pair.px_second = encode_pixel(y1, cb, cr, fmt);
    pair.frame_end = fe;
    return pair;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("[%0t] %s: got 0x%06h, want 0x%06h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Record the prediction for every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      pending_pairs.push_back(convert_macropixel(luma_first_i, chroma_blue_i, luma_second_i,
                                                 chroma_red_i, frame_end_in_i, fmt_shadow));
  end

  always @(posedge clk_i) begin
    rgb_pair_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", 32'(pixel_first_o), 32'd0);
      end else begin
        want = pending_pairs.pop_front();
        if (pixel_first_o !== want.px_first)
          report_mismatch("pixel_first", 32'(pixel_first_o), 32'(want.px_first));
        if (pixel_second_o !== want.px_second)
          report_mismatch("pixel_second", 32'(pixel_second_o), 32'(want.px_second));
        if (frame_end_out_o !== want.frame_end)
          report_mismatch("frame_end", 32'(frame_end_out_o), 32'(want.frame_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o === 1'b1 || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                 input logic [7:0] y1, input logic [7:0] v, input logic fe);
    start          <= 1'b1;
    luma_first_i   <= y0;
    chroma_blue_i  <= u;
    luma_second_i  <= y1;
    chroma_red_i   <= v;
    frame_end_in_i <= fe;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_sample();
    logic [7:0] corner[5] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128};
    if ($urandom_range(0, 9) == 0) return corner[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_macropixel();
    send_macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                    $urandom_range(0, 15) == 0);
  endtask

  // Hold start low for a random burst now and then, with calm stretches between.
  task automatic pace_sender(input bit allow_idle);
    int gap;
    if (!allow_idle) return;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
    end else if ($urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrOutFormat) fmt_shadow = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check_format();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrOutFormat;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== {31'd0, fmt_shadow})
      report_mismatch("out_format readback", got, 32'(fmt_shadow));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_corner_set();
    send_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    send_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
    send_macropixel(8'd20, 8'd0, 8'd20, 8'd0, 1'b0);
    send_macropixel(8'd240, 8'd200, 8'd100, 8'd60, 1'b1);
    send_macropixel(8'd128, 8'd127, 8'd129, 8'd128, 1'b0);
    send_macropixel(8'd81, 8'd90, 8'd145, 8'd240, 1'b0);
  endtask

  task automatic test_directed_rgb888();
    apb_check_format();
    send_corner_set();
    drain_pipeline();
  endtask

  task automatic test_directed_rgb565();
    apb_write(AddrOutFormat, 32'hFFFF_FFFF);
    apb_check_format();
    send_corner_set();
    drain_pipeline();
  endtask

  task automatic test_register_map();
    apb_write(AddrOutFormat, 32'hFFFF_FFFE);
    apb_write(AddrUnmapped, 32'h0000_0001);
    apb_check_format();
    send_macropixel(8'd200, 8'd30, 8'd60, 8'd220, 1'b1);
    send_macropixel(8'd255, 8'd128, 8'd16, 8'd128, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    logic fmt_plan[6] = '{FmtRgb888, FmtRgb565, FmtRgb565, FmtRgb888, FmtRgb565, FmtRgb888};
    foreach (fmt_plan[p]) begin
      apb_write(AddrOutFormat, ($urandom() & 32'hFFFF_FFFE) | 32'(fmt_plan[p]));
      repeat (140) begin
        send_random_macropixel();
        pace_sender(1'b1);
      end
      drain_pipeline();
    end
  endtask

  task automatic test_streaming_burst();
    apb_write(AddrOutFormat, 32'($urandom_range(0, 1)));
    apb_check_format();
    repeat (150) send_random_macropixel();
    start <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_rgb888();
    test_directed_rgb565();
    test_register_map();
    test_random_traffic();
    test_streaming_burst();
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pairs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ yuyv_to_rgb_pixel_converter.f @@
hdl/yuvrgb_pkg.sv
hdl/yuvrgb_prod.sv
hdl/yuvrgb_sum.sv
hdl/yuvrgb_pack.sv
hdl/yuyv_to_rgb_pixel_converter.sv
tb/sv/testbench.sv
